// ----- rtl/core/ybd_pkg.sv -----
// ----------------------------------------------------------------------------
// ybd_pkg
// Shared types, codes and constants of the yEnc byte decoder with CRC-32.
// ----------------------------------------------------------------------------
package ybd_pkg;

    // Byte counter width, default
    localparam int COUNT_BITS_DEF = 32;

    // Stream widths
    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 1;

    // Commands carried in s_tuser
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_END   = 2'd2;

    // Result kinds carried in m_tuser
    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // yEnc constants
    localparam logic [7:0]  ESC_CHAR     = 8'h3D;
    localparam logic [7:0]  ESC_OFFSET   = 8'd64;
    localparam logic [7:0]  SHIFT_OFFSET = 8'd42;
    localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT     = 32'hFFFFFFFF;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  data_byte;
        logic [31:0] expected_crc;
        logic [31:0] expected_size;
    } ybd_item_t;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] decoded_byte;
        logic       crc_ok;
        logic       size_ok;
    } ybd_result_t;

    // Reflected CRC-32 update over one byte, no inversion
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/yenc_byte_decoder_crc32_core.sv -----
// ----------------------------------------------------------------------------
// yenc_byte_decoder_crc32_core
// yEnc body decoder with running CRC-32 and end-of-part size/CRC check.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel carries one command per transaction: start of part, one
//   encoded body byte (line terminators already stripped), or end-of-part
//   check with the expected CRC and size from the end line.
//   Master channel returns a decoded byte, or for the end command a status
//   with crc_ok and size_ok. Start, a lone escape and command 3 give nothing.
//   m_tvalid rises when the decode stage loads the result register; a slave
//   transaction passes the input register and then the result register
//   before it can be taken on the master side.
//   Throughput is one transaction per cycle while the receiver keeps up; the
//   CRC-32 byte update in the decode stage sets the cycle.
//   Reset clears both stages, the escape mark and the count and loads the
//   CRC with all ones; a start command does the same to the part state.
//   When the receiver stalls, the result holds in the output register and
//   one more transaction waits in the input register; s_tready then drops.
// ----------------------------------------------------------------------------
module yenc_byte_decoder_crc32_core #(
    parameter int COUNT_BITS = ybd_pkg::COUNT_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [7:0] data_byte, [39:8] expected_crc, [71:40] expected_size
    input  logic [ybd_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] cmd
    input  logic [ybd_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [7:0] decoded_byte, [8] crc_ok, [9] size_ok, [15:10] zero
    output logic [ybd_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] result_kind
    output logic [ybd_pkg::M_TUSER_W-1:0] m_tuser
);
    import ybd_pkg::*;

    ybd_item_t   s_item;
    ybd_item_t   item;
    logic        item_valid;
    logic        item_ready;
    ybd_result_t result;

    assign s_item.cmd           = s_tuser[1:0];
    assign s_item.data_byte     = s_tdata[7:0];
    assign s_item.expected_crc  = s_tdata[39:8];
    assign s_item.expected_size = s_tdata[71:40];

    ybd_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    ybd_decode #(
        .COUNT_BITS (COUNT_BITS)
    ) u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .result     (result)
    );

    assign m_tdata = {6'd0, result.size_ok, result.crc_ok, result.decoded_byte};
    assign m_tuser = result.result_kind;

endmodule

// ----- rtl/core/ybd_in_reg.sv -----
// ----------------------------------------------------------------------------
// ybd_in_reg
// Input register stage: captures one transaction per cycle from the slave side while the decode stage takes items.
// ----------------------------------------------------------------------------
module ybd_in_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  ybd_pkg::ybd_item_t s_item,
    output logic              item_valid,
    input  logic              item_ready,
    output ybd_pkg::ybd_item_t item
);
    import ybd_pkg::*;

    logic      valid_reg, valid_next;
    ybd_item_t item_reg,  item_next;

    assign s_tready   = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
            if (s_tvalid) begin
                item_next = s_item;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

endmodule

// ----- rtl/core/ybd_decode.sv -----
// ----------------------------------------------------------------------------
// ybd_decode
// Decode stage: escape handling, offset removal, CRC-32 and byte count
// update, end-of-part compare, and the result register.
// ----------------------------------------------------------------------------
module ybd_decode #(
    parameter int COUNT_BITS = ybd_pkg::COUNT_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    output logic                item_ready,
    input  ybd_pkg::ybd_item_t  item,
    output logic                m_tvalid,
    input  logic                m_tready,
    output ybd_pkg::ybd_result_t result
);
    import ybd_pkg::*;

    localparam int CMP_W = (COUNT_BITS > 32) ? COUNT_BITS : 32;

    logic                  esc_reg,   esc_next;
    logic [31:0]           crc_reg,   crc_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  valid_reg, valid_next;
    ybd_result_t           res_reg,   res_next;

    logic        has_result;
    logic        advance;
    logic        esc_mark;
    logic [7:0]  dec_byte;
    logic [31:0] crc_upd;
    logic [CMP_W-1:0] size_exp, size_cnt;

    // A lone '=' only sets the mark
    assign esc_mark   = !esc_reg && (item.data_byte == ESC_CHAR);
    assign has_result = ((item.cmd == CMD_BYTE) && !esc_mark) || (item.cmd == CMD_END);
    assign item_ready = !has_result || !valid_reg || m_tready;
    assign advance    = item_valid && item_ready;

    assign dec_byte = item.data_byte - (esc_reg ? ESC_OFFSET : 8'd0) - SHIFT_OFFSET;
    assign crc_upd  = crc32_byte(crc_reg, dec_byte);
    assign size_exp = CMP_W'(item.expected_size);
    assign size_cnt = CMP_W'(count_reg);

    always_comb begin
        esc_next   = esc_reg;
        crc_next   = crc_reg;
        count_next = count_reg;
        valid_next = valid_reg;
        res_next   = res_reg;
        if (m_tready) begin
            valid_next = 1'b0;
        end
        if (advance) begin
            unique case (item.cmd)
                CMD_START: begin
                    esc_next   = 1'b0;
                    crc_next   = CRC_INIT;
                    count_next = '0;
                end
                CMD_BYTE: begin
                    if (esc_mark) begin
                        esc_next = 1'b1;
                    end else begin
                        esc_next = 1'b0;
                        crc_next = crc_upd;
                        if (count_reg != {COUNT_BITS{1'b1}}) begin
                            count_next = count_reg + 1'b1;
                        end
                        valid_next            = 1'b1;
                        res_next.result_kind  = KIND_BYTE;
                        res_next.decoded_byte = dec_byte;
                        res_next.crc_ok       = 1'b0;
                        res_next.size_ok      = 1'b0;
                    end
                end
                CMD_END: begin
                    valid_next            = 1'b1;
                    res_next.result_kind  = KIND_STATUS;
                    res_next.decoded_byte = 8'd0;
                    res_next.crc_ok       = (item.expected_crc == ~crc_reg);
                    res_next.size_ok      = (size_exp == size_cnt);
                end
                default: begin
                    // unused command: drop
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_reg   <= 1'b0;
            crc_reg   <= CRC_INIT;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            esc_reg   <= esc_next;
            crc_reg   <= crc_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
        res_reg <= res_next;
    end

    assign m_tvalid = valid_reg;
    assign result   = res_reg;

endmodule

// ----- rtl/core/ybd_checker.sv -----
// ----------------------------------------------------------------------------
// ybd_checker
// Port-level checks of the yEnc decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ybd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [ybd_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [ybd_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ybd_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [ybd_pkg::M_TUSER_W-1:0] m_tuser
);
    import ybd_pkg::*;

    // Nothing comes out in the cycle after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Byte result carries no status flags
    a_byte_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[0] == KIND_BYTE) |-> (m_tdata[9:8] == 2'b00))
        else $error("status flags set in byte result");

    // Status result carries a zero byte, padding stays zero
    a_status_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[0] == KIND_STATUS) |-> (m_tdata[7:0] == 8'd0))
        else $error("data byte set in status result");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:10] == 6'd0))
        else $error("padding bits not zero");

endmodule

bind yenc_byte_decoder_crc32_core ybd_checker u_ybd_checker (.*);
